FILE: design/assert_macros.svh
// assertion helpers used by the lookup core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define NKTL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nktl implication check failed");

// next-cycle implication, disabled while reset is high
`define NKTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nktl next-cycle check failed");

`endif

FILE: design/nktl_pkg.sv
package nktl_pkg;

   localparam int DATA_W = 16;
   localparam int DIST_W = 20;
   localparam int ABS_W  = 17;

   // starting best distance, above any real 17-bit distance
   localparam logic [DIST_W-1:0] START_DISTANCE = 20'd1000000;

   // register map and reset
   localparam logic       REG_ENTRIES_IN_USE = 1'b0;
   localparam logic [6:0] ENTRIES_RESET      = 7'd64;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      SEL_VOLT_ONE = 2'd0,
      SEL_VOLT_TWO = 2'd1,
      SEL_NONE     = 2'd2
   } sel_type;

   // one table row as stored in memory
   typedef struct packed {
      logic signed [DATA_W-1:0] command;
      logic signed [DATA_W-1:0] voltage_one;
      logic signed [DATA_W-1:0] voltage_two;
      logic signed [DATA_W-1:0] current;
   } entry_type;

   // compare unit result
   typedef struct packed {
      logic [ABS_W-1:0] distance;
      logic             better;
   } dist_result_type;

endpackage

FILE: design/nktl_if.sv
// request channel: table write or nearest-command query
interface nktl_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic        [5:0]  entry_index;
   logic signed [15:0] command_value;
   logic signed [15:0] voltage_one_in;
   logic signed [15:0] voltage_two_in;
   logic signed [15:0] current_in;
   logic        [1:0]  voltage_select;

   modport source (
      output valid, op, entry_index, command_value, voltage_one_in,
             voltage_two_in, current_in, voltage_select,
      input  ready
   );
   modport sink (
      input  valid, op, entry_index, command_value, voltage_one_in,
             voltage_two_in, current_in, voltage_select,
      output ready
   );
endinterface

// response channel: query result
interface nktl_rsp_if;
   logic               valid;
   logic               ready;
   logic        [5:0]  matched_index;
   logic signed [15:0] selected_voltage;
   logic signed [15:0] matched_current;

   modport source (
      output valid, matched_index, selected_voltage, matched_current,
      input  ready
   );
   modport sink (
      input  valid, matched_index, selected_voltage, matched_current,
      output ready
   );
endinterface

FILE: design/nktl_ram.sv
module nktl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/nktl_dist_unit.sv
module nktl_dist_unit
   import nktl_pkg::*;
(
   input  logic signed [DATA_W-1:0] key,
   input  logic signed [DATA_W-1:0] stored,
   input  logic        [DIST_W-1:0] best_dist,
   output dist_result_type          result
);

   logic signed [ABS_W-1:0] diff;
   logic        [ABS_W-1:0] abs_diff;

   // exact 17-bit difference, magnitude, strict compare against best
   always_comb begin
      diff            = ABS_W'(stored) - ABS_W'(key);
      abs_diff        = diff[ABS_W-1] ? ABS_W'(-diff) : ABS_W'(diff);
      result.distance = abs_diff;
      result.better   = DIST_W'(abs_diff) < best_dist;
   end

endmodule

FILE: design/nearest_key_table_lookup_core.sv
// Nearest-command lookup table.
// req_chan carries two kinds of transfer. A write (op 0) stores command,
// voltage one, voltage two and current at entry_index and gives no response;
// an index at or beyond TABLE_DEPTH is dropped. A query (op 1) searches
// entries 0 to entries_in_use-1 for the stored command nearest the query
// command, lower index winning ties, and returns one rsp_chan transfer with
// the index, the voltage picked by voltage_select (0 for none) and the current.
// A query reads one entry per cycle through the table memory's single read
// port into the shared compare unit; it scans N entries, N being
// entries_in_use clipped to TABLE_DEPTH (at least 1), then passes the drain
// and finish states before the response register is loaded. req_chan.ready
// is low while a query runs. The response sits in an output register; if the
// receiver stalls, a following write is still taken, but the next query
// result waits for the register to drain.
// After reset the table is cleared one entry per cycle with req_chan.ready
// low; entries_in_use resets to 64 and its APB register (address 0) may be
// written at any time.
`include "assert_macros.svh"

module nearest_key_table_lookup_core
   import nktl_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   nktl_req_if.sink    req_chan,
   nktl_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int LW = (CW > 7) ? CW : 7;
   localparam int IW = (CW > 6) ? CW : 6;
   localparam int EW = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic [AW-1:0]            addr_ff, addr_in;
   logic [AW-1:0]            last_ff, last_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [1:0]               sel_ff, sel_in;
   logic                     cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]            cmp_idx_ff, cmp_idx_in;
   logic [AW-1:0]            best_idx_ff, best_idx_in;
   logic [DIST_W-1:0]        best_dist_ff, best_dist_in;
   logic signed [DATA_W-1:0] best_volt_ff, best_volt_in;
   logic signed [DATA_W-1:0] best_cur_ff, best_cur_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [5:0]               rsp_idx_ff, rsp_idx_in;
   logic signed [DATA_W-1:0] rsp_volt_ff, rsp_volt_in;
   logic signed [DATA_W-1:0] rsp_cur_ff, rsp_cur_in;
   logic [6:0]               entries_ff, entries_in;

   logic            req_accept;
   logic            csr_write;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   entry_type       wr_entry;
   entry_type       rd_entry;
   logic [EW-1:0]   rd_data;
   logic [IW-1:0]   idx_wide;
   logic            idx_in_range;
   logic [LW-1:0]   clipped;
   logic [AW-1:0]   scan_last;
   logic [IW-1:0]   best_idx_wide;
   dist_result_type cmp_result;

   assign req_accept = req_chan.valid & req_chan.ready;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // write position check against the table depth
   assign idx_wide     = IW'(req_chan.entry_index);
   assign idx_in_range = idx_wide < IW'(TABLE_DEPTH);

   // entries searched: clipped to the depth, an empty search reads entry 0
   always_comb begin
      clipped   = (LW'(entries_ff) > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH)
                                                       : LW'(entries_ff);
      scan_last = (clipped == '0) ? '0 : AW'(clipped - LW'(1));
   end

   // memory write port: clearing pass or accepted write transfer
   always_comb begin
      wr_entry.command     = req_chan.command_value;
      wr_entry.voltage_one = req_chan.voltage_one_in;
      wr_entry.voltage_two = req_chan.voltage_two_in;
      wr_entry.current     = req_chan.current_in;
      if (state_ff == ST_CLEAR) begin
         wr_en    = 1'b1;
         wr_addr  = addr_ff;
         wr_entry = '0;
      end else begin
         wr_en   = req_accept && (req_chan.op == OP_WRITE) && idx_in_range;
         wr_addr = idx_wide[AW-1:0];
      end
   end

   nktl_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rd_entry = entry_type'(rd_data);

   // shared compare unit, one entry per cycle
   nktl_dist_unit u_dist (
      .key       (key_ff),
      .stored    (rd_entry.command),
      .best_dist (best_dist_ff),
      .result    (cmp_result)
   );

   assign best_idx_wide = IW'(best_idx_ff);

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      last_in      = last_ff;
      key_in       = key_ff;
      sel_in       = sel_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = addr_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      best_volt_in = best_volt_ff;
      best_cur_in  = best_cur_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_volt_in  = rsp_volt_ff;
      rsp_cur_in   = rsp_cur_ff;
      entries_in   = entries_ff;

      // config register write
      if (csr_write && (csr_paddr[2] == REG_ENTRIES_IN_USE)) begin
         entries_in = csr_pwdata[6:0];
      end

      // response transfer empties the output register
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // keep the nearest entry seen so far
      if (cmp_valid_ff && cmp_result.better) begin
         best_dist_in = DIST_W'(cmp_result.distance);
         best_idx_in  = cmp_idx_ff;
         best_cur_in  = rd_entry.current;
         case (sel_ff)
            SEL_VOLT_ONE: best_volt_in = rd_entry.voltage_one;
            SEL_VOLT_TWO: best_volt_in = rd_entry.voltage_two;
            default:      best_volt_in = '0;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + AW'(1);
            if (addr_ff == AW'(TABLE_DEPTH - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept && (req_chan.op == OP_QUERY)) begin
               key_in       = req_chan.command_value;
               sel_in       = req_chan.voltage_select;
               last_in      = scan_last;
               addr_in      = '0;
               best_dist_in = START_DISTANCE;
               best_idx_in  = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmp_valid_in = 1'b1;
            if (addr_ff == last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = best_idx_wide[5:0];
               rsp_volt_in  = best_volt_ff;
               rsp_cur_in   = best_cur_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         entries_ff   <= ENTRIES_RESET;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         entries_ff   <= entries_in;
      end
      last_ff      <= last_in;
      key_ff       <= key_in;
      sel_ff       <= sel_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      best_volt_ff <= best_volt_in;
      best_cur_ff  <= best_cur_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_volt_ff  <= rsp_volt_in;
      rsp_cur_ff   <= rsp_cur_in;
   end

   // channel and csr outputs
   assign req_chan.ready            = (state_ff == ST_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.matched_index    = rsp_idx_ff;
   assign rsp_chan.selected_voltage = rsp_volt_ff;
   assign rsp_chan.matched_current  = rsp_cur_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_ENTRIES_IN_USE) ? 32'(entries_ff) : '0;

   // compares never run past the last searched entry
   `NKTL_ASSERT_IMPL(a_cmp_in_range, clock, reset, cmp_valid_ff, cmp_idx_ff <= last_ff)
   // an accepted query starts the scan at entry 0
   `NKTL_ASSERT_NEXT(a_query_starts_scan, clock, reset,
      req_accept && (req_chan.op == OP_QUERY), (state_ff == ST_SCAN) && (addr_ff == '0))
   // a response only appears at the end of a scan
   `NKTL_ASSERT_IMPL(a_rsp_from_finish, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff == ST_FINISH))

endmodule

FILE: sim/nearest_key_table_lookup_core_tb.sv
`timescale 1ns / 1ps

module nearest_key_table_lookup_core_tb;
   import nktl_pkg::*;

   localparam int TABLE_DEPTH = 64;

   // signed Q8.8 extremes and bit patterns
   localparam logic signed [15:0] Q_MAX = 16'sh7FFF;
   localparam logic signed [15:0] Q_MIN = 16'sh8000;
   localparam logic signed [15:0] Q_ODD = 16'sh5555;
   localparam logic signed [15:0] Q_EVN = 16'shAAAA;

   // selector code outside the enum, also reads as none
   localparam logic [1:0] SEL_SPARE = 2'd3;

   // byte address of entries_in_use
   localparam logic [2:0] CFG_ADDR = {REG_ENTRIES_IN_USE, 2'b00};

   // one request transfer, with an optional hand-written expected result
   typedef struct packed {
      op_type             op;
      logic [5:0]         index;
      logic signed [15:0] command;
      logic signed [15:0] volt_one;
      logic signed [15:0] volt_two;
      logic signed [15:0] current;
      logic [1:0]         sel;
      logic               typed;
      logic [5:0]         exp_index;
      logic signed [15:0] exp_volt;
      logic signed [15:0] exp_current;
   } table_step_type;

   // one query response
   typedef struct packed {
      logic [5:0]         index;
      logic signed [15:0] volt;
      logic signed [15:0] current;
   } match_type;

   // directed rows: extremes, ties, every selector code
   localparam table_step_type DIRECTED_STEPS [20] = '{
      '{OP_QUERY, 6'd0,  Q_MAX, 16'sd0, 16'sd0, 16'sd0, SEL_VOLT_ONE, 1'b1, 6'd0, 16'sd0, 16'sd0},
      '{OP_QUERY, 6'd0,  Q_MIN, 16'sd0, 16'sd0, 16'sd0, SEL_NONE, 1'b1, 6'd0, 16'sd0, 16'sd0},
      '{OP_WRITE, 6'd0,  Q_MIN, Q_MAX, Q_MIN, Q_MAX, SEL_VOLT_ONE, 1'b0, 6'd0, 16'sd0, 16'sd0},
      '{OP_WRITE, 6'd63, Q_MAX, Q_MIN, Q_MAX, Q_MIN, SEL_VOLT_ONE, 1'b0, 6'd0, 16'sd0, 16'sd0},
      '{OP_QUERY, 6'd0,  Q_MAX, 16'sd0, 16'sd0, 16'sd0, SEL_VOLT_ONE, 1'b1, 6'd63, Q_MIN, Q_MIN},
      '{OP_QUERY, 6'd0,  Q_MAX, 16'sd0, 16'sd0, 16'sd0, SEL_VOLT_TWO, 1'b1, 6'd63, Q_MAX, Q_MIN},
      '{OP_QUERY, 6'd0,  Q_MIN, 16'sd0, 16'sd0, 16'sd0, SEL_VOLT_TWO, 1'b1, 6'd0, Q_MIN, Q_MAX},
      '{OP_QUERY, 6'd0,  16'sd0, 16'sd0, 16'sd0, 16'sd0, SEL_SPARE, 1'b0, 6'd0, 16'sd0, 16'sd0},
      '{OP_WRITE, 6'd10, 16'sd256, 16'sd100, 16'sd200, 16'sd300, SEL_VOLT_ONE, 1'b0,
        6'd0, 16'sd0, 16'sd0},
      '{OP_WRITE, 6'd11, 16'sd256, -16'sd1, -16'sd2, -16'sd3, SEL_VOLT_ONE, 1'b0,
        6'd0, 16'sd0, 16'sd0},
      '{OP_QUERY, 6'd0,  16'sd256, 16'sd0, 16'sd0, 16'sd0, SEL_VOLT_ONE, 1'b0,
        6'd0, 16'sd0, 16'sd0},
      '{OP_WRITE, 6'd12, 16'sd1000, 16'sd11, 16'sd12, 16'sd13, SEL_VOLT_ONE, 1'b0,
        6'd0, 16'sd0, 16'sd0},
      '{OP_WRITE, 6'd13, 16'sd1200, 16'sd21, 16'sd22, 16'sd23, SEL_VOLT_ONE, 1'b0,
        6'd0, 16'sd0, 16'sd0},
      '{OP_QUERY, 6'd0,  16'sd1100, 16'sd0, 16'sd0, 16'sd0, SEL_VOLT_TWO, 1'b0,
        6'd0, 16'sd0, 16'sd0},
      '{OP_QUERY, 6'd0,  -16'sd32767, 16'sd0, 16'sd0, 16'sd0, SEL_NONE, 1'b0,
        6'd0, 16'sd0, 16'sd0},
      '{OP_QUERY, 6'd0,  16'sd16000, 16'sd0, 16'sd0, 16'sd0, SEL_VOLT_ONE, 1'b0,
        6'd0, 16'sd0, 16'sd0},
      '{OP_WRITE, 6'd1,  Q_ODD, Q_EVN, Q_ODD, Q_EVN, SEL_VOLT_ONE, 1'b0, 6'd0, 16'sd0, 16'sd0},
      '{OP_WRITE, 6'd2,  Q_EVN, Q_ODD, Q_EVN, Q_ODD, SEL_VOLT_ONE, 1'b0, 6'd0, 16'sd0, 16'sd0},
      '{OP_QUERY, 6'd0,  Q_ODD, 16'sd0, 16'sd0, 16'sd0, SEL_VOLT_ONE, 1'b0, 6'd0, 16'sd0, 16'sd0},
      '{OP_QUERY, 6'd0,  Q_EVN, 16'sd0, 16'sd0, 16'sd0, SEL_VOLT_TWO, 1'b0, 6'd0, 16'sd0, 16'sd0}
   };

   // entries_in_use settings for the first phases: empty, one, saturated, edges
   localparam logic [6:0] EDGE_CFGS [7] = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd2, 7'd64, 7'd63};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   nktl_req_if req_bus ();
   nktl_rsp_if rsp_bus ();

   nearest_key_table_lookup_core #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the characterisation table and its register
   logic signed [15:0] cmd_tab   [TABLE_DEPTH] = '{default: '0};
   logic signed [15:0] volt1_tab [TABLE_DEPTH] = '{default: '0};
   logic signed [15:0] volt2_tab [TABLE_DEPTH] = '{default: '0};
   logic signed [15:0] curr_tab  [TABLE_DEPTH] = '{default: '0};
   logic [6:0]         entries_cfg = ENTRIES_RESET;

   match_type          match_queue [$];
   table_step_type     cur_step;
   logic signed [15:0] cluster_base = '0;
   int                 fail_count = 0;
   int                 result_count = 0;
   int                 burst_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // nearest stored command over the searched span, lower index on a tie
   function automatic match_type nearest_entry(input logic signed [15:0] key,
                                               input logic [1:0] sel);
      match_type m;
      int span, best, best_dist, d, i;
      span = (entries_cfg > TABLE_DEPTH) ? TABLE_DEPTH : entries_cfg;
      best = 0;
      best_dist = START_DISTANCE;
      for (i = 0; i < span; i++) begin
         d = cmd_tab[i] - key;
         if (d < 0) d = -d;
         if (d < best_dist) begin
            best_dist = d;
            best = i;
         end
      end
      m.index = best[5:0];
      case (sel)
         SEL_VOLT_ONE: m.volt = volt1_tab[best];
         SEL_VOLT_TWO: m.volt = volt2_tab[best];
         default:      m.volt = '0;
      endcase
      m.current = curr_tab[best];
      return m;
   endfunction

   // command values: extremes, a tight cluster for ties, or anything
   function automatic logic signed [15:0] pick_command();
      logic signed [15:0] value;
      case ($urandom_range(0, 9))
         0:       value = Q_MAX;
         1:       value = Q_MIN;
         2, 3, 4: value = cluster_base + 16'(2 * $urandom_range(0, 6));
         default: value = 16'($urandom);
      endcase
      return value;
   endfunction

   // random transfer; query keys land on or next to a stored command half the time
   function automatic table_step_type random_step();
      table_step_type step;
      int span;
      step = '0;
      span = (entries_cfg == 0) ? 1 :
             ((entries_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_cfg));
      step.op = ($urandom_range(0, 99) < 45) ? OP_WRITE : OP_QUERY;
      step.index = ($urandom_range(0, 2) != 0) ? 6'($urandom_range(0, span - 1))
                                                : 6'($urandom);
      step.volt_one = 16'($urandom);
      step.volt_two = 16'($urandom);
      step.current = 16'($urandom);
      step.sel = 2'($urandom);
      if (step.op == OP_QUERY && $urandom_range(0, 3) < 2)
         step.command = cmd_tab[$urandom_range(0, span - 1)]
                        + 16'($urandom_range(0, 2)) - 16'sd1;
      else
         step.command = pick_command();
      return step;
   endfunction

   // request sender, in bursts, often with gaps between them
   task automatic offer_request(input table_step_type step);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      cur_step = step;
      req_bus.op             <= step.op;
      req_bus.entry_index    <= step.index;
      req_bus.command_value  <= step.command;
      req_bus.voltage_one_in <= step.volt_one;
      req_bus.voltage_two_in <= step.volt_two;
      req_bus.current_in     <= step.current;
      req_bus.voltage_select <= step.sel;
      req_bus.valid          <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // stop offering and wait until every query has answered
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (match_queue.size() != 0) @(posedge clock);
      // a trailing table write may still be in flight
      repeat (10) @(posedge clock);
   endtask

   // apb write of entries_in_use, then read it back
   task automatic write_entries_cfg(input logic [6:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CFG_ADDR;
      csr_pwdata  <= {25'($urandom), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      entries_cfg = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[6:0] !== value) begin
         $error("entries_in_use readback: expected %0d, actual %0d", value, csr_prdata[6:0]);
         fail_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // response checking and shadow table update on each transfer
   always @(posedge clock) begin : scoreboard
      match_type want;
      match_type got;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count++;
            got = '{rsp_bus.matched_index, rsp_bus.selected_voltage, rsp_bus.matched_current};
            if (match_queue.size() == 0) begin
               $error("response with no query outstanding: matched_index %0d", got.index);
               fail_count++;
            end else begin
               want = match_queue.pop_front();
               if (got.index !== want.index) begin
                  $error("matched_index: expected %0d, actual %0d", want.index, got.index);
                  fail_count++;
               end
               if (got.volt !== want.volt) begin
                  $error("selected_voltage: expected %0d, actual %0d", want.volt, got.volt);
                  fail_count++;
               end
               if (got.current !== want.current) begin
                  $error("matched_current: expected %0d, actual %0d",
                         want.current, got.current);
                  fail_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.op == OP_WRITE) begin
               cmd_tab[req_bus.entry_index]   = req_bus.command_value;
               volt1_tab[req_bus.entry_index] = req_bus.voltage_one_in;
               volt2_tab[req_bus.entry_index] = req_bus.voltage_two_in;
               curr_tab[req_bus.entry_index]  = req_bus.current_in;
            end else if (cur_step.typed) begin
               match_queue.push_back('{cur_step.exp_index, cur_step.exp_volt,
                                       cur_step.exp_current});
            end else begin
               match_queue.push_back(nearest_entry(req_bus.command_value,
                                                   req_bus.voltage_select));
            end
         end
      end
   end

   // response stalls: runs of varying density plus one long hold-off
   initial begin : rsp_stall
      int  hold_left;
      int  run_left;
      int  stall_pct;
      bit  long_hold_done;
      hold_left = 0;
      run_left = 0;
      stall_pct = 0;
      long_hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!long_hold_done && result_count >= 60) begin
            long_hold_done = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               run_left = $urandom_range(4, 64);
               case ($urandom_range(0, 3))
                  0:       stall_pct = 0;
                  1:       stall_pct = 25;
                  2:       stall_pct = 60;
                  default: stall_pct = 85;
               endcase
            end
            run_left--;
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // reset, directed rows, then random phases under changing entries_in_use
   initial begin : stimulus
      int         p;
      int         n;
      logic [6:0] cfg;
      req_bus.valid          = 1'b0;
      req_bus.op             = OP_WRITE;
      req_bus.entry_index    = '0;
      req_bus.command_value  = '0;
      req_bus.voltage_one_in = '0;
      req_bus.voltage_two_in = '0;
      req_bus.current_in     = '0;
      req_bus.voltage_select = SEL_VOLT_ONE;
      cur_step = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (n = 0; n < $size(DIRECTED_STEPS); n++)
         offer_request(DIRECTED_STEPS[n]);

      for (p = 0; p < 15; p++) begin
         drain_results();
         if (p < $size(EDGE_CFGS))
            cfg = EDGE_CFGS[p];
         else if ($urandom_range(0, 3) == 0)
            cfg = 7'($urandom);
         else
            cfg = 7'($urandom_range(1, TABLE_DEPTH));
         write_entries_cfg(cfg);
         cluster_base = 16'($urandom);
         for (n = 0; n < ((p < $size(EDGE_CFGS)) ? 40 : 55); n++)
            offer_request(random_step());
      end

      drain_results();
      repeat (TABLE_DEPTH + 16) @(posedge clock);
      if (fail_count == 0 && match_queue.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #(64'd10_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/nktl_pkg.sv
design/nktl_if.sv
design/nktl_ram.sv
design/nktl_dist_unit.sv
design/nearest_key_table_lookup_core.sv
sim/nearest_key_table_lookup_core_tb.sv
